// ----- hw/rtl/tip_pkg.sv -----
// ----------------------------------------------------------------------------
// tip_pkg
// Shared types, character codes and helper functions for the text to
// integer parser.
// ----------------------------------------------------------------------------
package tip_pkg;

   // character codes that steer the parse
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_LA     = 8'h61;
   localparam logic [7:0] CHAR_LF     = 8'h66;
   localparam logic [7:0] CHAR_UA     = 8'h41;
   localparam logic [7:0] CHAR_UF     = 8'h46;
   localparam logic [7:0] LETTER_BIAS = 8'd10;

   localparam int unsigned VALUE_W = 32;

   // parse phases
   typedef enum logic [2:0] {
      PH_SKIP   = 3'd0,
      PH_SIGNED = 3'd1,
      PH_DOLLAR = 3'd2,
      PH_HELD   = 3'd3,
      PH_DIGITS = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   // parser state carried from one item to the next
   typedef struct packed {
      phase_type          phase;
      logic               is_negative;
      logic               hex_mode;
      logic [7:0]         held_char;
      logic [VALUE_W-1:0] accumulator;
   } tip_state_type;

   localparam tip_state_type STATE_RESET = '{
      phase:       PH_SKIP,
      is_negative: 1'b0,
      hex_mode:    1'b0,
      held_char:   8'h00,
      accumulator: '0
   };

   // one decoded digit
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   // outcome of one step: next state and an optional result
   typedef struct packed {
      tip_state_type      next_state;
      logic               emit;
      logic [VALUE_W-1:0] value;
   } step_type;

   // digit decode, letters only in hex mode, either case
   function automatic digit_type decode_digit(input logic [7:0] c, input logic hex);
      digit_type  d;
      logic [7:0] diff;
      d    = '0;
      diff = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         diff = c - CHAR_0;
         d.valid = 1'b1;
      end else if (hex && c >= CHAR_LA && c <= CHAR_LF) begin
         diff = c - CHAR_LA + LETTER_BIAS;
         d.valid = 1'b1;
      end else if (hex && c >= CHAR_UA && c <= CHAR_UF) begin
         diff = c - CHAR_UA + LETTER_BIAS;
         d.valid = 1'b1;
      end
      d.value = diff[3:0];
      return d;
   endfunction

   // accumulate one digit: times 16 or times 10 by shift and add, wraps
   function automatic logic [VALUE_W-1:0] shift_in(input logic [VALUE_W-1:0] acc,
                                                   input logic hex,
                                                   input logic [3:0] dig);
      logic [VALUE_W-1:0] scaled;
      scaled = hex ? (acc << 4) : ((acc << 3) + (acc << 1));
      return scaled + {{(VALUE_W-4){1'b0}}, dig};
   endfunction

endpackage

// ----- hw/rtl/text_to_integer_parser.sv -----
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streams ASCII characters in and gives one signed 32-bit value per string.
// ----------------------------------------------------------------------------
// One character item is taken every clock cycle while no tlast item waits
// for the result register. An item is held in the input register; the
// parse step runs between that register and the result register, so a
// string's value is registered at the edge where its tlast item leaves the
// input register. Items without tlast move on even while a result waits;
// only a tlast item waits in the input register until the result register
// is free. The rate is set by the combinational shift-add accumulate in
// the step logic.
// Leading spaces are skipped, '-' negates, '$' or an 'x' in second place
// selects hex, digits are taken up to the first non-digit, and the value
// wraps modulo 2^32. No result is produced for items without tlast.
module text_to_integer_parser (
   input  logic               clock,
   input  logic               reset,
   // request: tdata [7:0] char_code; tlast end_of_text
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   // response: tdata [31:0] parsed_value
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic signed [31:0] rsp_tdata
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_char_ff;
   logic                   in_last_ff;
   tip_pkg::tip_state_type state_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_data_ff;
   tip_pkg::step_type      step;
   logic                   advance;
   logic                   req_take;

   // item moves into the state; an end item also needs a free result register
   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   tip_step u_step (
      .state       (state_ff),
      .char_code   (in_char_ff),
      .end_of_text (in_last_ff),
      .step        (step)
   );

   // input register
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tip_pkg::STATE_RESET;
      end else if (advance) begin
         state_ff <= step.next_state;
      end
   end

   // result register
   assign rsp_valid_in = (advance && step.emit) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && step.emit) begin
         rsp_data_ff <= step.value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff.phase == tip_pkg::PH_SKIP
         && !state_ff.is_negative && !state_ff.hex_mode && state_ff.accumulator == 32'd0)
      else $error("state not cleared after end of text");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      advance && !in_last_ff && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result raised without an end item");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a full pipe");

   a_dollar_hex: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == tip_pkg::PH_DOLLAR |-> state_ff.hex_mode)
      else $error("dollar phase without hex mode");

endmodule

// ----- hw/rtl/tip_step.sv -----
// ----------------------------------------------------------------------------
// tip_step
// Next-state logic of the parser: takes the current state and one
// character and gives the following state and, on the last item, the value.
// ----------------------------------------------------------------------------
module tip_step (
   input  tip_pkg::tip_state_type state,
   input  logic [7:0]             char_code,
   input  logic                   end_of_text,
   output tip_pkg::step_type      step
);

   tip_pkg::tip_state_type mid;
   tip_pkg::digit_type     held_dig;
   tip_pkg::digit_type     char_dig;
   tip_pkg::digit_type     end_dig;
   logic [31:0]            acc_held;

   // decode of the held character and of the incoming one
   assign held_dig = tip_pkg::decode_digit(state.held_char, state.hex_mode);
   assign char_dig = tip_pkg::decode_digit(char_code, state.hex_mode);
   assign acc_held = tip_pkg::shift_in(state.accumulator, state.hex_mode, held_dig.value);
   assign end_dig  = tip_pkg::decode_digit(mid.held_char, mid.hex_mode);

   // per-character phase update
   always_comb begin
      mid = state;
      case (state.phase)
         tip_pkg::PH_SKIP: begin
            if (char_code == tip_pkg::CHAR_SPACE) begin
               mid.phase = tip_pkg::PH_SKIP;
            end else if (char_code == tip_pkg::CHAR_MINUS) begin
               mid.is_negative = 1'b1;
               mid.phase       = tip_pkg::PH_SIGNED;
            end else if (char_code == tip_pkg::CHAR_DOLLAR) begin
               mid.hex_mode = 1'b1;
               mid.phase    = tip_pkg::PH_DOLLAR;
            end else begin
               mid.held_char = char_code;
               mid.phase     = tip_pkg::PH_HELD;
            end
         end
         tip_pkg::PH_SIGNED: begin
            if (char_code == tip_pkg::CHAR_DOLLAR) begin
               mid.hex_mode = 1'b1;
               mid.phase    = tip_pkg::PH_DOLLAR;
            end else begin
               mid.held_char = char_code;
               mid.phase     = tip_pkg::PH_HELD;
            end
         end
         tip_pkg::PH_DOLLAR: begin
            mid.held_char = char_code;
            mid.phase     = tip_pkg::PH_HELD;
         end
         tip_pkg::PH_HELD: begin
            if (char_code == tip_pkg::CHAR_X) begin
               // prefix such as 0x: held character dropped
               mid.hex_mode = 1'b1;
               mid.phase    = tip_pkg::PH_DIGITS;
            end else if (!held_dig.valid) begin
               mid.phase = tip_pkg::PH_DONE;
            end else if (char_dig.valid) begin
               mid.accumulator = tip_pkg::shift_in(acc_held, state.hex_mode,
                                                   char_dig.value);
               mid.phase       = tip_pkg::PH_DIGITS;
            end else begin
               mid.accumulator = acc_held;
               mid.phase       = tip_pkg::PH_DONE;
            end
         end
         tip_pkg::PH_DIGITS: begin
            if (char_dig.valid) begin
               mid.accumulator = tip_pkg::shift_in(state.accumulator, state.hex_mode,
                                                   char_dig.value);
            end else begin
               mid.phase = tip_pkg::PH_DONE;
            end
         end
         default: begin
            mid = state;
         end
      endcase
   end

   // end of text: flush a held character, emit and return to reset
   // a character only becomes held before any digit, so the accumulator is
   // still the one from the state register
   always_comb begin
      logic [31:0] acc_final;
      acc_final = mid.accumulator;
      if (mid.phase == tip_pkg::PH_HELD && end_dig.valid) begin
         acc_final = tip_pkg::shift_in(state.accumulator, mid.hex_mode, end_dig.value);
      end
      step.emit  = end_of_text;
      step.value = mid.is_negative ? (32'd0 - acc_final) : acc_final;
      step.next_state = end_of_text ? tip_pkg::STATE_RESET : mid;
   end

endmodule
